FILE: hdl/swecb_pkg.sv
// ----------------------------------------------------------------------------
// Write/erase command buffer package
// Shared widths, request and result codes, reset values and the slot type.
// ----------------------------------------------------------------------------
package swecb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 5;
  localparam int unsigned LBA_W         = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned SIZE_W        = 4;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [LBA_W-1:0]  LBA_LIMIT_RST   = 16'd100;
  localparam logic [SIZE_W-1:0] ERASE_LIMIT_RST = 4'd10;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FWRITE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FERASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LBA_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT = 1'd1;

  typedef struct packed {
    logic              vld;
    logic              is_erase;
    logic [LBA_W-1:0]  addr;
    logic [DATA_W-1:0] value;
  } slot_t;

  // Command broadcast to every cell for one step of the sequencer.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_OUT,
    OP_APPEND,
    OP_DROP,
    OP_MERGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [3:0]        sel;
    logic [LBA_W-1:0]  addr;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: hdl/swecb_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// A generic stream channel with source and sink views.
// ----------------------------------------------------------------------------
interface swecb_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/swecb_cell.sv
// ----------------------------------------------------------------------------
// Buffer cell
// Holds one slot; takes its neighbor's on a shift or a drop with sel <= IDX.
// ----------------------------------------------------------------------------
module swecb_cell #(
  parameter logic [3:0] IDX = 4'd0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swecb_pkg::cell_cmd_t cmd,
  input  logic                app_is_erase,
  input  swecb_pkg::slot_t    nbr,
  output swecb_pkg::slot_t    slot
);

  swecb_pkg::slot_t slot_r;
  swecb_pkg::slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    case (cmd.op)
      swecb_pkg::OP_SHIFT_OUT: slot_nxt = nbr;
      swecb_pkg::OP_DROP: begin
        if (cmd.sel <= IDX) slot_nxt = nbr;
      end
      swecb_pkg::OP_APPEND: begin
        if (cmd.sel == IDX) begin
          slot_nxt.vld      = 1'b1;
          slot_nxt.is_erase = app_is_erase;
          slot_nxt.addr     = cmd.addr;
          slot_nxt.value    = cmd.value;
        end
      end
      swecb_pkg::OP_MERGE: begin
        if (cmd.sel == IDX) begin
          slot_nxt.addr  = cmd.addr;
          slot_nxt.value = cmd.value;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
    end
    slot_r.is_erase <= slot_nxt.is_erase;
    slot_r.addr     <= slot_nxt.addr;
    slot_r.value    <= slot_nxt.value;
  end

  assign slot = slot_r;

endmodule

FILE: hdl/ssd_write_erase_command_buffer.sv
// ----------------------------------------------------------------------------
// Write/erase command buffer
// Ordered buffer of pending writes and erase ranges kept in a row of cells.
// ----------------------------------------------------------------------------
// A read, write or erase that passes its checks is handled by a sequencer that
// examines one cell per cycle, newest to oldest. After its transfer it is first
// decoded, then the scan visits buffered entries until it closes, and then the
// result is loaded. An error result is loaded straight from the decode step.
// A flush presents one entry per cycle while the output is not stalled, and a
// write or an erase that meets a full buffer first flushes it the same way.
// The next request is taken the cycle after the last result of the previous
// one has transferred.
module ssd_write_erase_command_buffer #(
  parameter int unsigned BUFFER_DEPTH = swecb_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swecb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swecb_pkg::CFG_DATA_W-1:0]    cfg_data,
  swecb_if.sink                               in_ch,
  swecb_if.source                             out_ch
);

  localparam int unsigned IW = 4;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_APPLY, S_EMIT
  } state_t;

  state_t st_r;
  logic [1:0]  req_r;
  logic [15:0] lba_r;
  logic [31:0] wd_r;
  logic [3:0]  sz_r;
  logic [15:0] lba_limit_r;
  logic [3:0]  erase_limit_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic        done_r;
  logic        hit_r;
  logic [31:0] rdata_r;
  logic        skip_r;
  logic        newest_r;
  logic        after_flush_r;
  logic        ovld_r;
  logic [2:0]  okind_r;
  logic        ohit_r;
  logic [15:0] olba_r;
  logic [31:0] odata_r;
  logic [3:0]  osize_r;
  logic        olast_r;

  swecb_pkg::cell_cmd_t cmd;
  swecb_pkg::slot_t     slots [BUFFER_DEPTH+1];
  logic [15:0] mlo;
  logic [4:0]  msz;

  assign slots[BUFFER_DEPTH] = '0;

  for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
    swecb_cell #(.IDX(IW'(g))) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .app_is_erase(req_r == swecb_pkg::REQ_ERASE),
      .nbr(slots[g+1]), .slot(slots[g])
    );
  end

  // This is the entry under scan.
  swecb_pkg::slot_t cur;
  logic [16:0] el, eh, lo, hi;
  logic wr_hit, er_cov, in_rng, enclosed, covers, ovl;

  always_comb begin
    cur = '0;
    for (int k = 0; k < BUFFER_DEPTH; k++) begin
      if (idx_r == IW'(k)) cur = slots[k];
    end
    el       = {1'b0, cur.addr};
    eh       = el + {13'd0, cur.value[3:0]};
    lo       = {1'b0, lba_r};
    hi       = lo + {13'd0, sz_r};
    wr_hit   = !cur.is_erase && cur.addr == lba_r;
    er_cov   = cur.is_erase && lo >= el && lo < eh;
    in_rng   = el >= lo && el < hi;
    enclosed = el >= lo && eh <= hi;
    covers   = el <= lo && eh >= hi;
    ovl      = !((eh - 17'd1) < lo || el > (hi - 17'd1)) && eh != 17'd0 && hi != 17'd0;
    mlo      = (el < lo) ? cur.addr : lba_r;
    msz      = 5'(((eh > hi) ? eh : hi) - {1'b0, mlo});
  end

  logic bad;
  assign bad = req_r != swecb_pkg::REQ_FLUSH &&
               (lba_r >= lba_limit_r ||
                (req_r == swecb_pkg::REQ_ERASE && sz_r > erase_limit_r));

  assign in_ch.ready = st_r == S_IDLE && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.payload = {okind_r, ohit_r, olba_r, odata_r, osize_r, olast_r};

  logic obusy;
  assign obusy = ovld_r && !out_ch.ready;

  logic ld_out;
  assign ld_out = !obusy &&
                  ((st_r == S_EMIT && bad) || st_r == S_FLUSH || st_r == S_APPLY);

  always_comb begin
    cmd = '0;
    cmd.op = swecb_pkg::OP_HOLD;
    cmd.sel = idx_r;
    if (st_r == S_FLUSH && !obusy && cnt_r != '0) cmd.op = swecb_pkg::OP_SHIFT_OUT;
    if (st_r == S_SCAN && !done_r && idx_r < IW'(cnt_r) && cur.vld) begin
      if (req_r == swecb_pkg::REQ_WRITE && wr_hit) cmd.op = swecb_pkg::OP_DROP;
      if (req_r == swecb_pkg::REQ_ERASE) begin
        if ((!cur.is_erase && in_rng) || (cur.is_erase && enclosed))
          cmd.op = swecb_pkg::OP_DROP;
        else if (cur.is_erase && !covers && newest_r && ovl &&
                 msz <= {1'b0, erase_limit_r}) begin
          cmd.op = swecb_pkg::OP_MERGE;
          cmd.addr = mlo;
          cmd.value = 32'(msz);
        end
      end
    end
    if (st_r == S_APPLY && req_r != swecb_pkg::REQ_READ && !skip_r &&
        cnt_r < CW'(BUFFER_DEPTH)) begin
      cmd.op = swecb_pkg::OP_APPEND;
      cmd.sel = IW'(cnt_r);
      cmd.addr = lba_r;
      cmd.value = (req_r == swecb_pkg::REQ_ERASE) ? {28'd0, sz_r} : wd_r;
    end
  end

  logic scan_end;
  assign scan_end = idx_r == '0 ||
                    (req_r == swecb_pkg::REQ_READ && (wr_hit || er_cov)) ||
                    (req_r == swecb_pkg::REQ_WRITE && wr_hit) ||
                    (req_r == swecb_pkg::REQ_ERASE && cur.is_erase &&
                     cmd.op != swecb_pkg::OP_DROP && (covers || newest_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovld_r <= 1'b0;
      cnt_r <= '0;
      lba_limit_r <= swecb_pkg::LBA_LIMIT_RST;
      erase_limit_r <= swecb_pkg::ERASE_LIMIT_RST;
    end else begin
      if (cfg_we && cfg_index == swecb_pkg::CFG_LBA_LIMIT) lba_limit_r <= cfg_data;
      if (cfg_we && cfg_index == swecb_pkg::CFG_ERASE_LIMIT) erase_limit_r <= cfg_data[3:0];
      if (ld_out) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            {req_r, lba_r, wd_r, sz_r} <= in_ch.payload;
            after_flush_r <= 1'b0;
            st_r <= S_EMIT;
            okind_r <= swecb_pkg::KIND_ERROR;
            done_r <= 1'b1;
          end
        end
        S_EMIT: begin
          hit_r <= 1'b0; rdata_r <= '0; skip_r <= 1'b0;
          idx_r <= IW'(cnt_r - CW'(1)); newest_r <= 1'b1; done_r <= cnt_r == '0;
          if (bad) begin
            if (!obusy) begin
              okind_r <= swecb_pkg::KIND_ERROR; ohit_r <= 1'b0;
              olba_r <= '0; odata_r <= '0; osize_r <= '0; olast_r <= 1'b1;
              st_r <= S_IDLE;
            end
          end else if (req_r == swecb_pkg::REQ_FLUSH ||
                       (req_r != swecb_pkg::REQ_READ && cnt_r == CW'(BUFFER_DEPTH)
                        && !after_flush_r)) begin
            st_r <= S_FLUSH;
          end else begin
            st_r <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (!obusy) begin
            if (cnt_r != '0) begin
              okind_r <= slots[0].is_erase ? swecb_pkg::KIND_FERASE : swecb_pkg::KIND_FWRITE;
              ohit_r <= 1'b0;
              olba_r <= slots[0].addr;
              odata_r <= slots[0].is_erase ? '0 : slots[0].value;
              osize_r <= slots[0].is_erase ? slots[0].value[3:0] : '0;
              olast_r <= req_r == swecb_pkg::REQ_FLUSH && cnt_r == CW'(1);
              cnt_r <= cnt_r - CW'(1);
              if (req_r != swecb_pkg::REQ_FLUSH && cnt_r == CW'(1)) begin
                after_flush_r <= 1'b1;
                st_r <= S_EMIT;
              end else if (cnt_r == CW'(1)) begin
                st_r <= S_IDLE;
              end
            end else begin
              okind_r <= swecb_pkg::KIND_ACCEPT; ohit_r <= 1'b0;
              olba_r <= '0; odata_r <= '0; osize_r <= '0; olast_r <= 1'b1;
              st_r <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (done_r) begin
            st_r <= S_APPLY;
          end else begin
            if (req_r == swecb_pkg::REQ_READ && (wr_hit || er_cov)) begin
              hit_r <= 1'b1; rdata_r <= wr_hit ? cur.value : '0;
            end
            if (cmd.op == swecb_pkg::OP_DROP) cnt_r <= cnt_r - CW'(1);
            if (cmd.op == swecb_pkg::OP_MERGE ||
                (req_r == swecb_pkg::REQ_ERASE && cur.is_erase &&
                 cmd.op != swecb_pkg::OP_DROP && covers))
              skip_r <= 1'b1;
            if (req_r == swecb_pkg::REQ_ERASE && cmd.op != swecb_pkg::OP_DROP)
              newest_r <= 1'b0;
            if (scan_end) done_r <= 1'b1;
            else idx_r <= idx_r - IW'(1);
          end
        end
        S_APPLY: begin
          if (!obusy) begin
            if (req_r != swecb_pkg::REQ_READ && !skip_r && cnt_r < CW'(BUFFER_DEPTH))
              cnt_r <= cnt_r + CW'(1);
            okind_r <= (req_r == swecb_pkg::REQ_READ) ? swecb_pkg::KIND_READ
                                                     : swecb_pkg::KIND_ACCEPT;
            ohit_r <= (req_r == swecb_pkg::REQ_READ) && hit_r;
            olba_r <= '0; osize_r <= '0; olast_r <= 1'b1;
            odata_r <= (req_r == swecb_pkg::REQ_READ) ? rdata_r : '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(BUFFER_DEPTH))
    else $error("slot count above depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ch.ready) |=> ovld_r && $stable(out_ch.payload))
    else $error("result lost while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == S_IDLE)
    else $error("request taken while busy");

endmodule
